// ===== rtl/swk_pkg.sv =====
// Shared types, constants and tables for the swerve wheel kinematics block.
package swk_pkg;

   localparam int WHEELS        = 4;
   localparam int CORDIC_STEPS  = 16;
   localparam int STEP_W        = 4;
   localparam int DW            = 36;
   localparam int ZW            = 24;
   localparam int MAW           = 36;
   localparam int MBW           = 20;
   localparam int PW            = MAW + MBW;
   localparam int WPW           = 33;
   localparam int HALF_TURN_Z   = 1048576;
   localparam int INV_GAIN      = 39797;
   localparam int SCALE_SHIFT   = 13;
   localparam int GAIN_SHIFT    = 16;
   localparam int RATIO_SHIFT   = 34;
   localparam int SPEED_RAW_W   = PW - RATIO_SHIFT;
   localparam int SPEED_MAX     = 32767;

   typedef enum logic [2:0] {
      REG_OFFSET_X      = 3'd0,
      REG_OFFSET_Y      = 3'd1,
      REG_CENTRE_FL     = 3'd2,
      REG_CENTRE_RL     = 3'd3,
      REG_CENTRE_RR     = 3'd4,
      REG_CENTRE_FR     = 3'd5,
      REG_SPEED_RATIO   = 3'd6
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PREP_X, ST_PREP_Y, ST_CORD_GO, ST_CORD_WAIT,
      ST_SCALE_GO, ST_SCALE_WAIT, ST_ANG_WRAP, ST_ANG_DIFF, ST_ANG_FLIP,
      ST_ANG_STORE, ST_GAIN_GO, ST_GAIN_WAIT, ST_RATIO_GO, ST_RATIO_WAIT,
      ST_SPEED, ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_w;
      logic [12:0]        meas_front_left;
      logic [12:0]        meas_rear_left;
      logic [12:0]        meas_rear_right;
      logic [12:0]        meas_front_right;
   } req_payload_type;

   typedef struct packed {
      logic [13:0]        angle_front_left;
      logic [13:0]        angle_rear_left;
      logic [13:0]        angle_rear_right;
      logic [13:0]        angle_front_right;
      logic signed [15:0] speed_front_left;
      logic signed [15:0] speed_rear_left;
      logic signed [15:0] speed_rear_right;
      logic signed [15:0] speed_front_right;
   } rsp_payload_type;

   // Handshake between the sequencer and a shared iterative unit.
   typedef struct packed {
      logic start;
   } unit_ctrl_type;

   typedef struct packed {
      logic done;
   } unit_stat_type;

   // Arctangent of 2^-i in units of 2^-21 turn, rounded.
   function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         4'd0:    v = 24'sd262144;
         4'd1:    v = 24'sd154753;
         4'd2:    v = 24'sd81767;
         4'd3:    v = 24'sd41506;
         4'd4:    v = 24'sd20834;
         4'd5:    v = 24'sd10427;
         4'd6:    v = 24'sd5215;
         4'd7:    v = 24'sd2608;
         4'd8:    v = 24'sd1304;
         4'd9:    v = 24'sd652;
         4'd10:   v = 24'sd326;
         4'd11:   v = 24'sd163;
         4'd12:   v = 24'sd81;
         4'd13:   v = 24'sd41;
         4'd14:   v = 24'sd20;
         4'd15:   v = 24'sd10;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/swk_chan_if.sv =====
// Valid/ready channel interface carrying one payload struct.
interface swk_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/swk_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per clock cycle.
module swk_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  swk_pkg::unit_ctrl_type         ctrl,
   input  logic signed [swk_pkg::DW-1:0]  x_in,
   input  logic signed [swk_pkg::DW-1:0]  y_in,
   output swk_pkg::unit_stat_type         stat,
   output logic signed [swk_pkg::ZW-1:0]  z_out,
   output logic signed [swk_pkg::DW-1:0]  mag_out
);
   logic signed [swk_pkg::DW-1:0]  x_ff, y_ff, x_in_nx, y_in_nx;
   logic signed [swk_pkg::ZW-1:0]  z_ff, z_in;
   logic [swk_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                           busy_ff, busy_in, done_ff, done_in, zero_ff, zero_in;
   logic signed [swk_pkg::DW-1:0]  dx, dy;

   always_comb begin
      x_in_nx = x_ff;
      y_in_nx = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      dx      = y_ff >>> step_ff;
      dy      = x_ff >>> step_ff;
      if (ctrl.start) begin
         zero_in = (x_in == '0) && (y_in == '0);
         step_in = '0;
         busy_in = 1'b1;
         // Vectors in the left half-plane are turned by half a turn first.
         if (x_in < 0) begin
            x_in_nx = -x_in;
            y_in_nx = -y_in;
            z_in    = (y_in >= 0) ? swk_pkg::ZW'(swk_pkg::HALF_TURN_Z)
                                  : -swk_pkg::ZW'(swk_pkg::HALF_TURN_Z);
         end else begin
            x_in_nx = x_in;
            y_in_nx = y_in;
            z_in    = '0;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in_nx = x_ff + dx;
            y_in_nx = y_ff - dy;
            z_in    = z_ff + swk_pkg::atan_entry(step_ff);
         end else begin
            x_in_nx = x_ff - dx;
            y_in_nx = y_ff + dy;
            z_in    = z_ff - swk_pkg::atan_entry(step_ff);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == swk_pkg::STEP_W'(swk_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in_nx;
      y_ff    <= y_in_nx;
      z_ff    <= z_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   assign stat.done = done_ff;
   assign z_out     = zero_ff ? '0 : z_ff;
   assign mag_out   = zero_ff ? '0 : x_ff;
endmodule

// ===== rtl/swk_mul.sv =====
// Serial shift-add multiplier: signed multiplicand, unsigned multiplier, one bit per cycle.
module swk_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  swk_pkg::unit_ctrl_type         ctrl,
   input  logic signed [swk_pkg::MAW-1:0] a_in,
   input  logic [swk_pkg::MBW-1:0]        b_in,
   output swk_pkg::unit_stat_type         stat,
   output logic signed [swk_pkg::PW-1:0]  product
);
   localparam int CW = $clog2(swk_pkg::MBW);

   logic signed [swk_pkg::PW-1:0] acc_ff, acc_in, a_ff, a_in_nx;
   logic [swk_pkg::MBW-1:0]       b_ff, b_in_nx;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in_nx = a_ff;
      b_in_nx = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         acc_in  = '0;
         a_in_nx = swk_pkg::PW'(a_in);
         b_in_nx = b_in;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in_nx = a_ff <<< 1;
         b_in_nx = b_ff >> 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(swk_pkg::MBW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in_nx;
      b_ff   <= b_in_nx;
      cnt_ff <= cnt_in;
   end

   assign stat.done = done_ff;
   assign product   = acc_ff;
endmodule

// ===== rtl/swerve_wheel_kinematics.sv =====
// Top level of the four-wheel swerve drive inverse kinematics block.
// Each request transaction carries a chassis velocity command and the four measured steering
// angles; one response transaction returns four target steering angles and four signed drive
// speeds, in the wheel order front left, rear left, rear right, front right. The wheels are
// handled one after another by a sequencer that drives two shared iterative units: a vectoring
// CORDIC that takes one rotation per cycle and a shift-add multiplier that takes one multiplier
// bit per cycle, used three times per wheel for angle scaling, gain correction and speed ratio.
// A moving command therefore runs through all four wheels before the response is ready, while
// an all-zero command skips the wheel sequence and is answered with the previous angles and
// zero speeds. The request side is not ready while a command is being worked on; a finished
// response waits in an output register, so a new command can be taken while the previous
// response has not yet been collected. Configuration registers are written through the csr
// port and should only be changed while the block is idle.
module swerve_wheel_kinematics #(
   parameter int ENCODER_COUNTS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   swk_chan_if.sink    req_ch,
   swk_chan_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   // Angle work is done in 1/256 encoder count units.
   localparam int EW = ($clog2(ENCODER_COUNTS + 1) > 13) ? $clog2(ENCODER_COUNTS + 1) : 13;
   localparam int TW = EW + 8 + 3;
   localparam logic signed [TW-1:0] FULL    = TW'(ENCODER_COUNTS * 256);
   localparam logic signed [TW-1:0] HALF    = TW'(ENCODER_COUNTS * 128);
   localparam logic signed [TW-1:0] QUARTER = TW'(ENCODER_COUNTS * 64);

   // Configuration registers.
   logic [15:0] ox_ff, oy_ff;
   logic [12:0] centre_ff [swk_pkg::WHEELS];
   logic [19:0] ratio_ff;

   // Command and per-wheel state.
   swk_pkg::state_type            state_ff, state_in;
   logic signed [15:0]            vx_ff, vy_ff, vw_ff;
   logic [12:0]                   meas_ff [swk_pkg::WHEELS];
   logic signed [swk_pkg::WPW-1:0] wx_ff, wy_ff;
   logic [1:0]                    wheel_ff;
   logic                          zero_cmd_ff;
   logic signed [TW-1:0]          t_ff, diff_ff;
   logic [13:0]                   last_ff  [swk_pkg::WHEELS];
   logic                          rev_ff   [swk_pkg::WHEELS];
   logic signed [15:0]            speed_ff [swk_pkg::WHEELS];
   logic                          rsp_valid_ff;
   swk_pkg::rsp_payload_type      rsp_data_ff;

   // Shared unit connections.
   swk_pkg::unit_ctrl_type        cord_ctrl, mul_ctrl;
   swk_pkg::unit_stat_type        cord_stat, mul_stat;
   logic signed [swk_pkg::DW-1:0] cord_x, cord_y, cord_mag;
   logic signed [swk_pkg::ZW-1:0] cord_z;
   logic signed [swk_pkg::MAW-1:0] mul_a;
   logic [swk_pkg::MBW-1:0]       mul_b;
   logic signed [swk_pkg::PW-1:0] mul_p;

   logic                          req_accept, req_zero, rsp_load;
   logic signed [swk_pkg::WPW-1:0] w_prod;
   logic signed [TW-1:0]          t_raw, t_new, act, err, t_flip, t_fin;
   logic                          flip;
   logic [swk_pkg::SPEED_RAW_W-1:0] s_raw;
   logic signed [15:0]            s_sat, s_out;

   function automatic logic signed [TW-1:0] wrap_once(input logic signed [TW-1:0] v);
      logic signed [TW-1:0] r;
      if (v > FULL) begin
         r = v - FULL;
      end else if (v < 0) begin
         r = v + FULL;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign req_accept = req_ch.valid && req_ch.ready;
   assign req_zero   = (req_ch.data.vel_x == '0) && (req_ch.data.vel_y == '0) &&
                       (req_ch.data.vel_w == '0);
   assign rsp_load   = (state_ff == swk_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   // Yaw contribution products, one per cycle through a single multiplier.
   assign w_prod = vw_ff * $signed({1'b0, (state_ff == swk_pkg::ST_PREP_X) ? ox_ff : oy_ff});

   // Wheel velocity components in Q5.26; the yaw term sign depends on the corner.
   always_comb begin
      cord_y = ($signed({{(swk_pkg::DW - 30){vx_ff[15]}}, vx_ff, 14'b0})) +
               ((wheel_ff == 2'd0 || wheel_ff == 2'd3) ? swk_pkg::DW'(wy_ff)
                                                       : -swk_pkg::DW'(wy_ff));
      cord_x = ($signed({{(swk_pkg::DW - 30){vy_ff[15]}}, vy_ff, 14'b0})) +
               ((wheel_ff == 2'd0 || wheel_ff == 2'd1) ? swk_pkg::DW'(wx_ff)
                                                       : -swk_pkg::DW'(wx_ff));
   end

   // Angle path: scale, add centre, wrap, flip decision, final wrap.
   always_comb begin
      t_raw  = $signed(mul_p[swk_pkg::SCALE_SHIFT +: TW]);
      t_new  = wrap_once(TW'({centre_ff[wheel_ff], 8'b0}) + t_raw);
      act    = TW'({meas_ff[wheel_ff], 8'b0});
      if (diff_ff > HALF) begin
         err = diff_ff - FULL;
      end else if (diff_ff < -HALF) begin
         err = diff_ff + FULL;
      end else begin
         err = diff_ff;
      end
      flip   = (err > QUARTER) || (err < -QUARTER);
      t_flip = flip ? (t_ff - HALF) : t_ff;
      t_fin  = wrap_once(t_ff);
   end

   // Speed path: saturate and apply drive direction.
   always_comb begin
      s_raw = mul_p[swk_pkg::RATIO_SHIFT +: swk_pkg::SPEED_RAW_W];
      s_sat = (s_raw > swk_pkg::SPEED_RAW_W'(swk_pkg::SPEED_MAX)) ? 16'sd32767
                                                                   : $signed(s_raw[15:0]);
      s_out = rev_ff[wheel_ff] ? s_sat : -s_sat;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swk_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = req_zero ? swk_pkg::ST_FINISH : swk_pkg::ST_PREP_X;
            end
         end
         swk_pkg::ST_PREP_X:    state_in = swk_pkg::ST_PREP_Y;
         swk_pkg::ST_PREP_Y:    state_in = swk_pkg::ST_CORD_GO;
         swk_pkg::ST_CORD_GO:   state_in = swk_pkg::ST_CORD_WAIT;
         swk_pkg::ST_CORD_WAIT: begin
            if (cord_stat.done) begin
               state_in = swk_pkg::ST_SCALE_GO;
            end
         end
         swk_pkg::ST_SCALE_GO:  state_in = swk_pkg::ST_SCALE_WAIT;
         swk_pkg::ST_SCALE_WAIT: begin
            if (mul_stat.done) begin
               state_in = swk_pkg::ST_ANG_WRAP;
            end
         end
         swk_pkg::ST_ANG_WRAP:  state_in = swk_pkg::ST_ANG_DIFF;
         swk_pkg::ST_ANG_DIFF:  state_in = swk_pkg::ST_ANG_FLIP;
         swk_pkg::ST_ANG_FLIP:  state_in = swk_pkg::ST_ANG_STORE;
         swk_pkg::ST_ANG_STORE: state_in = swk_pkg::ST_GAIN_GO;
         swk_pkg::ST_GAIN_GO:   state_in = swk_pkg::ST_GAIN_WAIT;
         swk_pkg::ST_GAIN_WAIT: begin
            if (mul_stat.done) begin
               state_in = swk_pkg::ST_RATIO_GO;
            end
         end
         swk_pkg::ST_RATIO_GO:  state_in = swk_pkg::ST_RATIO_WAIT;
         swk_pkg::ST_RATIO_WAIT: begin
            if (mul_stat.done) begin
               state_in = swk_pkg::ST_SPEED;
            end
         end
         swk_pkg::ST_SPEED: begin
            state_in = (wheel_ff == 2'd3) ? swk_pkg::ST_FINISH : swk_pkg::ST_CORD_GO;
         end
         swk_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = swk_pkg::ST_IDLE;
            end
         end
         default: state_in = swk_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: unit starts and multiplier operand selection.
   always_comb begin
      cord_ctrl.start = 1'b0;
      mul_ctrl.start  = 1'b0;
      mul_a           = swk_pkg::MAW'(cord_z);
      mul_b           = swk_pkg::MBW'(ENCODER_COUNTS);
      case (state_ff)
         swk_pkg::ST_CORD_GO: cord_ctrl.start = 1'b1;
         swk_pkg::ST_SCALE_GO: begin
            mul_ctrl.start = 1'b1;
         end
         swk_pkg::ST_GAIN_GO: begin
            mul_ctrl.start = 1'b1;
            mul_a          = cord_mag;
            mul_b          = swk_pkg::MBW'(swk_pkg::INV_GAIN);
         end
         swk_pkg::ST_RATIO_GO: begin
            mul_ctrl.start = 1'b1;
            mul_a          = $signed(mul_p[swk_pkg::GAIN_SHIFT +: swk_pkg::MAW]);
            mul_b          = ratio_ff;
         end
         default: begin
            mul_ctrl.start = 1'b0;
         end
      endcase
   end

   assign req_ch.ready = (state_ff == swk_pkg::ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swk_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         ratio_ff     <= '0;
         for (int i = 0; i < swk_pkg::WHEELS; i++) begin
            centre_ff[i] <= '0;
            last_ff[i]   <= '0;
            rev_ff[i]    <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (swk_pkg::reg_index_type'(csr_index))
               swk_pkg::REG_OFFSET_X:    ox_ff        <= csr_wdata[15:0];
               swk_pkg::REG_OFFSET_Y:    oy_ff        <= csr_wdata[15:0];
               swk_pkg::REG_CENTRE_FL:   centre_ff[0] <= csr_wdata[12:0];
               swk_pkg::REG_CENTRE_RL:   centre_ff[1] <= csr_wdata[12:0];
               swk_pkg::REG_CENTRE_RR:   centre_ff[2] <= csr_wdata[12:0];
               swk_pkg::REG_CENTRE_FR:   centre_ff[3] <= csr_wdata[12:0];
               swk_pkg::REG_SPEED_RATIO: ratio_ff     <= csr_wdata;
               default: begin
                  ratio_ff <= ratio_ff;
               end
            endcase
         end
         if (state_ff == swk_pkg::ST_ANG_FLIP) begin
            rev_ff[wheel_ff] <= flip;
         end
         if (state_ff == swk_pkg::ST_ANG_STORE) begin
            last_ff[wheel_ff] <= t_fin[8 +: 14];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // Payload registers.
      if (req_accept) begin
         vx_ff       <= req_ch.data.vel_x;
         vy_ff       <= req_ch.data.vel_y;
         vw_ff       <= req_ch.data.vel_w;
         meas_ff[0]  <= req_ch.data.meas_front_left;
         meas_ff[1]  <= req_ch.data.meas_rear_left;
         meas_ff[2]  <= req_ch.data.meas_rear_right;
         meas_ff[3]  <= req_ch.data.meas_front_right;
         zero_cmd_ff <= req_zero;
         wheel_ff    <= '0;
      end
      if (state_ff == swk_pkg::ST_PREP_X) begin
         wx_ff <= w_prod;
      end
      if (state_ff == swk_pkg::ST_PREP_Y) begin
         wy_ff <= w_prod;
      end
      if (state_ff == swk_pkg::ST_ANG_WRAP) begin
         t_ff <= t_new;
      end
      if (state_ff == swk_pkg::ST_ANG_DIFF) begin
         diff_ff <= t_ff - act;
      end
      if (state_ff == swk_pkg::ST_ANG_FLIP) begin
         t_ff <= t_flip;
      end
      if (state_ff == swk_pkg::ST_SPEED) begin
         speed_ff[wheel_ff] <= s_out;
         wheel_ff           <= wheel_ff + 1'b1;
      end
      if (rsp_load) begin
         rsp_data_ff.angle_front_left  <= last_ff[0];
         rsp_data_ff.angle_rear_left   <= last_ff[1];
         rsp_data_ff.angle_rear_right  <= last_ff[2];
         rsp_data_ff.angle_front_right <= last_ff[3];
         rsp_data_ff.speed_front_left  <= zero_cmd_ff ? '0 : speed_ff[0];
         rsp_data_ff.speed_rear_left   <= zero_cmd_ff ? '0 : speed_ff[1];
         rsp_data_ff.speed_rear_right  <= zero_cmd_ff ? '0 : speed_ff[2];
         rsp_data_ff.speed_front_right <= zero_cmd_ff ? '0 : speed_ff[3];
      end
   end

   swk_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cord_ctrl),
      .x_in    (cord_x),
      .y_in    (cord_y),
      .stat    (cord_stat),
      .z_out   (cord_z),
      .mag_out (cord_mag)
   );

   swk_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mul_ctrl),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .stat    (mul_stat),
      .product (mul_p)
   );

   // A zero command skips all arithmetic and goes straight to the response.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_zero) |=> (state_ff == swk_pkg::ST_FINISH))
      else $error("zero command did not bypass the wheel sequence");

   // The CORDIC may only finish while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      cord_stat.done |-> (state_ff == swk_pkg::ST_CORD_WAIT))
      else $error("CORDIC finished outside its wait state");

   // The multiplier may only finish while the sequencer waits for a product.
   assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == swk_pkg::ST_SCALE_WAIT ||
                         state_ff == swk_pkg::ST_GAIN_WAIT ||
                         state_ff == swk_pkg::ST_RATIO_WAIT))
      else $error("multiplier finished outside a wait state");

   // A response is loaded only from the finish state and leaves the block idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == swk_pkg::ST_IDLE))
      else $error("response load did not complete the transaction");
endmodule
